### rtl/core/hlpf_pkg.sv
// Heartbeat LED pulse fader: shared types, register indexes, constants and states.
// Used by hlpf_div, heartbeat_led_pulse_fader_core, hlpf_checker and testbench.
package hlpf_pkg;

  localparam int DIV_W  = 16;
  localparam int DIV_CW = $clog2(DIV_W);
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_FADE_PERIOD = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_RATE    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_RATE    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FIRST_BEAT  = 3'd3;

  localparam logic [15:0] BEAT_MS_PER_MIN = 16'd60000;
  localparam logic [15:0] FADE_SCALE      = 16'd256;
  localparam logic [7:0]  FULL_LEVEL      = 8'hFF;
  localparam logic [1:0]  FINGER_CODE     = 2'd3;

  localparam logic [6:0]  FADE_PERIOD_RST = 7'd10;
  localparam logic [7:0]  MIN_RATE_RST    = 8'd30;
  localparam logic [8:0]  MAX_RATE_RST    = 9'd240;
  localparam logic [15:0] FIRST_BEAT_RST  = 16'd100;
  localparam logic [8:0]  HELD_RATE_RST   = 9'd60;

  typedef struct packed {
    logic       req_type;
    logic       read_ok;
    logic [1:0] finger_status;
    logic [6:0] confidence;
    logic [8:0] pulse_bpm;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        beat;
    logic [15:0] beat_period_ms;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PERIOD,
    ST_DIV_FADE,
    ST_DIV_STEP,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/heartbeat_led_pulse_fader_core.sv
// Sensor word or plain tick: the word moves ST_IDLE to ST_EMIT, which registers the result
// word and returns to ST_IDLE, where the next word is accepted. Beat tick: ST_IDLE, ST_DIV_PERIOD,
// ST_DIV_FADE, ST_DIV_STEP, ST_EMIT, with three 16-step divisions on the shared divider
// (60000 / rate, period / fade period, 256 / periods). A stalled result holds the next in ST_EMIT.
// One word in flight; the next word is accepted while the result word waits.
// Synchronous active-low reset loads register defaults and restarts both timers.
// Depends on hlpf_pkg and hlpf_div.
module heartbeat_led_pulse_fader_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hlpf_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hlpf_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [hlpf_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [hlpf_pkg::CFG_DW-1:0]   cfg_wdata
);

  hlpf_pkg::state_t    state_r, state_nxt;
  hlpf_pkg::div_req_t  div_req;
  hlpf_pkg::div_rsp_t  div_rsp;
  hlpf_pkg::out_word_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [6:0]  fade_period_r, fade_period_nxt;
  logic [7:0]  min_rate_r, min_rate_nxt;
  logic [8:0]  max_rate_r, max_rate_nxt;
  logic [15:0] first_beat_r, first_beat_nxt;

  logic [8:0]  held_rate_r, held_rate_nxt;
  logic        sensor_ok_r, sensor_ok_nxt;
  logic [1:0]  finger_seen_r, finger_seen_nxt;
  logic        rate_valid_r, rate_valid_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  fade_step_r, fade_step_nxt;
  logic [15:0] beat_cd_r, beat_cd_nxt;
  logic [6:0]  fade_cd_r, fade_cd_nxt;
  logic [15:0] period_held_r, period_held_nxt;
  logic        beat_r, beat_nxt;

  logic [8:0]  rate_clamp;
  logic [8:0]  rate_use;
  logic [6:0]  fp_use;
  logic [8:0]  step_sum;
  logic        rate_ok;

  hlpf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  always_comb begin
    if (held_rate_r > max_rate_r) begin
      rate_clamp = max_rate_r;
    end else if (held_rate_r < {1'b0, min_rate_r}) begin
      rate_clamp = {1'b0, min_rate_r};
    end else begin
      rate_clamp = held_rate_r;
    end
  end

  assign rate_use = (rate_clamp == 9'd0) ? 9'd1 : rate_clamp;
  assign fp_use   = (fade_period_r == 7'd0) ? 7'd1 : fade_period_r;
  assign step_sum = div_rsp.quotient[8:0] + 9'd1;
  assign rate_ok  = (in_data.confidence != 7'd0) && (in_data.pulse_bpm != 9'd0);

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    fade_period_nxt = fade_period_r;
    min_rate_nxt    = min_rate_r;
    max_rate_nxt    = max_rate_r;
    first_beat_nxt  = first_beat_r;
    held_rate_nxt   = held_rate_r;
    sensor_ok_nxt   = sensor_ok_r;
    finger_seen_nxt = finger_seen_r;
    rate_valid_nxt  = rate_valid_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    blue_nxt        = blue_r;
    fade_step_nxt   = fade_step_r;
    beat_cd_nxt     = beat_cd_r;
    fade_cd_nxt     = fade_cd_r;
    period_held_nxt = period_held_r;
    beat_nxt        = beat_r;
    div_req         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        hlpf_pkg::REG_FADE_PERIOD: begin
          fade_period_nxt = cfg_wdata[6:0];
          if (period_held_r == 16'd0) begin
            fade_cd_nxt = cfg_wdata[6:0];
          end
        end
        hlpf_pkg::REG_MIN_RATE: min_rate_nxt = cfg_wdata[7:0];
        hlpf_pkg::REG_MAX_RATE: max_rate_nxt = cfg_wdata[8:0];
        hlpf_pkg::REG_FIRST_BEAT: begin
          first_beat_nxt = cfg_wdata;
          if (period_held_r == 16'd0) begin
            beat_cd_nxt = cfg_wdata;
          end
        end
        default: ;
      endcase
    end

    case (state_r)
      hlpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          beat_nxt  = 1'b0;
          state_nxt = hlpf_pkg::ST_EMIT;
          if (!in_data.req_type) begin
            sensor_ok_nxt = in_data.read_ok;
            if (in_data.read_ok) begin
              finger_seen_nxt = in_data.finger_status;
              rate_valid_nxt  = rate_ok;
              if ((in_data.finger_status == hlpf_pkg::FINGER_CODE) && rate_ok) begin
                held_rate_nxt = in_data.pulse_bpm;
              end
            end
          end else if (beat_cd_r <= 16'd1) begin
            beat_nxt = 1'b1;
            if (!sensor_ok_r) begin
              red_nxt   = hlpf_pkg::FULL_LEVEL;
              green_nxt = hlpf_pkg::FULL_LEVEL;
              blue_nxt  = hlpf_pkg::FULL_LEVEL;
            end else if (finger_seen_r == hlpf_pkg::FINGER_CODE) begin
              red_nxt   = rate_valid_r ? 8'd0 : hlpf_pkg::FULL_LEVEL;
              green_nxt = hlpf_pkg::FULL_LEVEL;
              blue_nxt  = 8'd0;
            end else begin
              red_nxt   = hlpf_pkg::FULL_LEVEL;
              green_nxt = 8'd0;
              blue_nxt  = 8'd0;
            end
            div_req.start    = 1'b1;
            div_req.dividend = hlpf_pkg::BEAT_MS_PER_MIN;
            div_req.divisor  = {7'd0, rate_use};
            state_nxt        = hlpf_pkg::ST_DIV_PERIOD;
          end else begin
            beat_cd_nxt = beat_cd_r - 16'd1;
            if (fade_cd_r <= 7'd1) begin
              red_nxt     = (red_r >= fade_step_r) ? red_r - fade_step_r : 8'd0;
              green_nxt   = (green_r >= fade_step_r) ? green_r - fade_step_r : 8'd0;
              blue_nxt    = (blue_r >= fade_step_r) ? blue_r - fade_step_r : 8'd0;
              fade_cd_nxt = fade_period_r;
            end else begin
              fade_cd_nxt = fade_cd_r - 7'd1;
            end
          end
        end
      end
      hlpf_pkg::ST_DIV_PERIOD: begin
        if (div_rsp.done) begin
          period_held_nxt  = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = {9'd0, fp_use};
          state_nxt        = hlpf_pkg::ST_DIV_FADE;
        end
      end
      hlpf_pkg::ST_DIV_FADE: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = hlpf_pkg::FADE_SCALE;
          div_req.divisor  = (div_rsp.quotient == 16'd0) ? 16'd1 : div_rsp.quotient;
          state_nxt        = hlpf_pkg::ST_DIV_STEP;
        end
      end
      hlpf_pkg::ST_DIV_STEP: begin
        if (div_rsp.done) begin
          fade_step_nxt = (step_sum > 9'd255) ? hlpf_pkg::FULL_LEVEL : step_sum[7:0];
          beat_cd_nxt   = period_held_r;
          fade_cd_nxt   = fade_period_r;
          state_nxt     = hlpf_pkg::ST_EMIT;
        end
      end
      hlpf_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.red            = red_r;
          out_data_nxt.green          = green_r;
          out_data_nxt.blue           = blue_r;
          out_data_nxt.beat           = beat_r;
          out_data_nxt.beat_period_ms = period_held_r;
          state_nxt                   = hlpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hlpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hlpf_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      fade_period_r <= hlpf_pkg::FADE_PERIOD_RST;
      min_rate_r    <= hlpf_pkg::MIN_RATE_RST;
      max_rate_r    <= hlpf_pkg::MAX_RATE_RST;
      first_beat_r  <= hlpf_pkg::FIRST_BEAT_RST;
      held_rate_r   <= hlpf_pkg::HELD_RATE_RST;
      sensor_ok_r   <= 1'b0;
      finger_seen_r <= 2'd0;
      rate_valid_r  <= 1'b0;
      red_r         <= hlpf_pkg::FULL_LEVEL;
      green_r       <= hlpf_pkg::FULL_LEVEL;
      blue_r        <= hlpf_pkg::FULL_LEVEL;
      fade_step_r   <= 8'd0;
      beat_cd_r     <= hlpf_pkg::FIRST_BEAT_RST;
      fade_cd_r     <= hlpf_pkg::FADE_PERIOD_RST;
      period_held_r <= 16'd0;
      beat_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      fade_period_r <= fade_period_nxt;
      min_rate_r    <= min_rate_nxt;
      max_rate_r    <= max_rate_nxt;
      first_beat_r  <= first_beat_nxt;
      held_rate_r   <= held_rate_nxt;
      sensor_ok_r   <= sensor_ok_nxt;
      finger_seen_r <= finger_seen_nxt;
      rate_valid_r  <= rate_valid_nxt;
      red_r         <= red_nxt;
      green_r       <= green_nxt;
      blue_r        <= blue_nxt;
      fade_step_r   <= fade_step_nxt;
      beat_cd_r     <= beat_cd_nxt;
      fade_cd_r     <= fade_cd_nxt;
      period_held_r <= period_held_nxt;
      beat_r        <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != hlpf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_beat_has_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beat |-> out_data.beat_period_ms != 16'd0)
    else $error("beat word without a period");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == hlpf_pkg::ST_DIV_PERIOD) ||
                     (state_r == hlpf_pkg::ST_DIV_FADE) ||
                     (state_r == hlpf_pkg::ST_DIV_STEP))
    else $error("divider finished outside a division state");

  a_step_set_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hlpf_pkg::ST_EMIT) && (period_held_r != 16'd0) |-> fade_step_r != 8'd0)
    else $error("fade step zero after a beat");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hlpf_pkg::ST_EMIT) && !(out_valid && out_stall) |=> out_valid)
    else $error("result word not loaded");

endmodule

### rtl/core/hlpf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hlpf_pkg for widths and request/response structs.
module hlpf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  hlpf_pkg::div_req_t div_req,
  output hlpf_pkg::div_rsp_t div_rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [hlpf_pkg::DIV_CW-1:0]  cnt_r, cnt_nxt;
  logic [hlpf_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [hlpf_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [hlpf_pkg::DIV_W-1:0]   dsr_r, dsr_nxt;
  logic [hlpf_pkg::DIV_W:0]     shifted;
  logic [hlpf_pkg::DIV_W:0]     diff;
  logic                         fits;

  assign shifted = {rem_r, quo_r[hlpf_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (div_req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = div_req.dividend;
      dsr_nxt  = div_req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[hlpf_pkg::DIV_W-1:0] : shifted[hlpf_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[hlpf_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + hlpf_pkg::DIV_CW'(1);
      if (cnt_r == hlpf_pkg::DIV_CW'(hlpf_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = quo_r;

endmodule

### bench/hlpf_checker.sv
// Heartbeat LED pulse fader checker: watches the sensor/tick, LED and register ports,
// predicts every LED word and compares it with the block's output, reporting a mismatch field by field.
// Depends on hlpf_pkg for the word types, register indexes and constants.
module hlpf_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  hlpf_pkg::in_word_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  hlpf_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [hlpf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hlpf_pkg::CFG_DW-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending
);

  logic [6:0]  fade_ms;
  logic [7:0]  rate_lo;
  logic [8:0]  rate_hi;
  logic [15:0] first_ms;

  logic [8:0]  rate_kept;
  logic        sens_ok;
  logic [1:0]  finger;
  logic        rate_good;
  logic [7:0]  lvl_r;
  logic [7:0]  lvl_g;
  logic [7:0]  lvl_b;
  logic [7:0]  step;
  logic [15:0] beat_left;
  logic [6:0]  fade_left;
  logic [15:0] period;

  hlpf_pkg::out_word_t led_due[$];

  function automatic logic [7:0] dim(input logic [7:0] lvl, input logic [7:0] s);
    return (lvl >= s) ? lvl - s : 8'd0;
  endfunction

  task automatic load_defaults();
    fade_ms   = hlpf_pkg::FADE_PERIOD_RST;
    rate_lo   = hlpf_pkg::MIN_RATE_RST;
    rate_hi   = hlpf_pkg::MAX_RATE_RST;
    first_ms  = hlpf_pkg::FIRST_BEAT_RST;
    rate_kept = hlpf_pkg::HELD_RATE_RST;
    sens_ok   = 1'b0;
    finger    = '0;
    rate_good = 1'b0;
    lvl_r     = hlpf_pkg::FULL_LEVEL;
    lvl_g     = hlpf_pkg::FULL_LEVEL;
    lvl_b     = hlpf_pkg::FULL_LEVEL;
    step      = '0;
    beat_left = hlpf_pkg::FIRST_BEAT_RST;
    fade_left = hlpf_pkg::FADE_PERIOD_RST;
    period    = '0;
  endtask

  task automatic write_reg(input logic [hlpf_pkg::CFG_IW-1:0] idx,
                           input logic [hlpf_pkg::CFG_DW-1:0] val);
    case (idx)
      hlpf_pkg::REG_FADE_PERIOD: begin
        fade_ms = val[6:0];
        if (period == 0) fade_left = fade_ms;
      end
      hlpf_pkg::REG_MIN_RATE: rate_lo = val[7:0];
      hlpf_pkg::REG_MAX_RATE: rate_hi = val[8:0];
      hlpf_pkg::REG_FIRST_BEAT: begin
        first_ms = val;
        if (period == 0) beat_left = first_ms;
      end
      default: ;
    endcase
  endtask

  task automatic start_flash();
    int unsigned rate;
    int unsigned fp;
    int unsigned periods;
    int unsigned stepv;
    if (!sens_ok) begin
      {lvl_r, lvl_g, lvl_b} = {hlpf_pkg::FULL_LEVEL, hlpf_pkg::FULL_LEVEL,
                               hlpf_pkg::FULL_LEVEL};
    end else if (finger == hlpf_pkg::FINGER_CODE && rate_good) begin
      {lvl_r, lvl_g, lvl_b} = {8'd0, hlpf_pkg::FULL_LEVEL, 8'd0};
    end else if (finger == hlpf_pkg::FINGER_CODE) begin
      {lvl_r, lvl_g, lvl_b} = {hlpf_pkg::FULL_LEVEL, hlpf_pkg::FULL_LEVEL, 8'd0};
    end else begin
      {lvl_r, lvl_g, lvl_b} = {hlpf_pkg::FULL_LEVEL, 8'd0, 8'd0};
    end
    rate = rate_kept;
    if (rate > rate_hi) rate = rate_hi;
    else if (rate < rate_lo) rate = rate_lo;
    if (rate == 0) rate = 1;
    period = 16'(hlpf_pkg::BEAT_MS_PER_MIN / rate);
    fp = (fade_ms == 0) ? 1 : fade_ms;
    periods = period / fp;
    if (periods == 0) periods = 1;
    stepv = hlpf_pkg::FADE_SCALE / periods + 1;
    step = (stepv > hlpf_pkg::FULL_LEVEL) ? hlpf_pkg::FULL_LEVEL : 8'(stepv);
    beat_left = period;
    fade_left = fade_ms;
  endtask

  task automatic advance_led(input hlpf_pkg::in_word_t w, output hlpf_pkg::out_word_t r);
    r.beat = 1'b0;
    if (!w.req_type) begin
      sens_ok = w.read_ok;
      if (w.read_ok) begin
        finger = w.finger_status;
        rate_good = (w.confidence != 0) && (w.pulse_bpm != 0);
        if (w.finger_status == hlpf_pkg::FINGER_CODE && rate_good) rate_kept = w.pulse_bpm;
      end
    end else if (beat_left <= 1) begin
      start_flash();
      r.beat = 1'b1;
    end else begin
      beat_left = beat_left - 1;
      if (fade_left <= 1) begin
        lvl_r = dim(lvl_r, step);
        lvl_g = dim(lvl_g, step);
        lvl_b = dim(lvl_b, step);
        fade_left = fade_ms;
      end else begin
        fade_left = fade_left - 1;
      end
    end
    r.red = lvl_r;
    r.green = lvl_g;
    r.blue = lvl_b;
    r.beat_period_ms = period;
  endtask

  always @(posedge clk) begin : watch
    hlpf_pkg::out_word_t want;
    if (!rst_n) begin
      load_defaults();
      led_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) begin
        if (led_due.size() == 0) begin
          fail_count++;
          $display("%0t: LED word mismatch: expected none, got %h", $time, out_data);
        end else begin
          want = led_due.pop_front();
          if (out_data !== want) begin
            fail_count++;
            $display("%0t: LED word mismatch: expected r=%0d g=%0d b=%0d beat=%0d per=%0d,%s",
                     $time, want.red, want.green, want.blue, want.beat,
                     want.beat_period_ms,
                     $sformatf(" got r=%0d g=%0d b=%0d beat=%0d per=%0d",
                               out_data.red, out_data.green, out_data.blue,
                               out_data.beat, out_data.beat_period_ms));
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_led(in_data, want);
        led_due.push_back(want);
      end
    end
    pending = led_due.size();
  end

endmodule

### bench/testbench.sv
// Heartbeat LED pulse fader bench top: clock, reset, sensor/tick word and register
// stimulus with random idling and output stalls, and the verdict. Depends on hlpf_pkg,
// the core and hlpf_checker, which predicts and compares the LED words.
module testbench;

  localparam logic REQ_SENSOR = 1'b0;
  localparam logic REQ_TICK   = 1'b1;
  localparam logic [1:0] FINGER_NONE   = 2'd0;
  localparam logic [1:0] FINGER_OBJECT = 2'd1;
  localparam logic [1:0] FINGER_OTHER  = 2'd2;
  localparam logic [hlpf_pkg::CFG_IW-1:0] REG_NONE = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  hlpf_pkg::in_word_t          in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  hlpf_pkg::out_word_t         out_data;
  logic                        cfg_we = 1'b0;
  logic [hlpf_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [hlpf_pkg::CFG_DW-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  bit idle_on = 1'b0;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  heartbeat_led_pulse_fader_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hlpf_checker led_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic hlpf_pkg::in_word_t sensor_word(input logic ok, input logic [1:0] fs,
                                                     input logic [6:0] conf,
                                                     input logic [8:0] bpm);
    hlpf_pkg::in_word_t w;
    w.req_type = REQ_SENSOR;
    w.read_ok = ok;
    w.finger_status = fs;
    w.confidence = conf;
    w.pulse_bpm = bpm;
    return w;
  endfunction

  function automatic hlpf_pkg::in_word_t tick_word(input logic [18:0] junk);
    return hlpf_pkg::in_word_t'({REQ_TICK, junk});
  endfunction

  function automatic hlpf_pkg::in_word_t rand_word(input int tick_pct);
    hlpf_pkg::in_word_t w;
    w.req_type = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_SENSOR;
    w.read_ok = ($urandom_range(0, 3) != 0);
    w.finger_status = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3))
                                                  : hlpf_pkg::FINGER_CODE;
    w.confidence = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
    if ($urandom_range(0, 7) == 0) w.pulse_bpm = '0;
    else if ($urandom_range(0, 9) < 7) w.pulse_bpm = 9'($urandom_range(200, 511));
    else w.pulse_bpm = 9'($urandom_range(0, 511));
    return w;
  endfunction

  task automatic send_word(input hlpf_pkg::in_word_t w);
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [hlpf_pkg::CFG_IW-1:0] idx,
                           input logic [hlpf_pkg::CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic setup_phase(input logic [hlpf_pkg::CFG_DW-1:0] fade,
                             input logic [hlpf_pkg::CFG_DW-1:0] lo,
                             input logic [hlpf_pkg::CFG_DW-1:0] hi,
                             input logic [hlpf_pkg::CFG_DW-1:0] first);
    in_valid <= 1'b0;
    wait_idle();
    cfg_write(hlpf_pkg::REG_FADE_PERIOD, fade);
    cfg_write(hlpf_pkg::REG_MIN_RATE, lo);
    cfg_write(hlpf_pkg::REG_MAX_RATE, hi);
    cfg_write(hlpf_pkg::REG_FIRST_BEAT, first);
    cfg_we <= 1'b0;
    idle_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic run_random(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) send_word(rand_word(tick_pct));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_NONE, '1);
    setup_phase(16'd3, 16'd1, 16'd511, 16'd5);
    send_word(sensor_word(1'b1, hlpf_pkg::FINGER_CODE, 7'd127, 9'd511));
    send_word(sensor_word(1'b0, hlpf_pkg::FINGER_CODE, 7'd127, 9'd511));
    repeat (5) send_word(tick_word('1));
    send_word(sensor_word(1'b1, FINGER_NONE, 7'd0, 9'd0));
    repeat (3) send_word(tick_word('0));
    send_word(sensor_word(1'b1, hlpf_pkg::FINGER_CODE, 7'd0, 9'd511));
    send_word(sensor_word(1'b1, hlpf_pkg::FINGER_CODE, 7'd1, 9'd0));
    send_word(sensor_word(1'b1, FINGER_OTHER, 7'd100, 9'd300));
    send_word(sensor_word(1'b1, FINGER_OBJECT, 7'd64, 9'd1));
    send_word(sensor_word(1'b1, hlpf_pkg::FINGER_CODE, 7'd100, 9'd256));
    repeat (4) send_word(tick_word('1));

    setup_phase(16'd1, 16'd255, 16'd511, 16'hFFFF);
    run_random(250, 80);
    setup_phase(16'd127, 16'd250, 16'd511, 16'd100);
    run_random(200, 80);
    setup_phase(16'd10, 16'd30, 16'd240, 16'd100);
    run_random(150, 85);
    setup_phase(16'd100, 16'd200, 16'd300, 16'd1);
    run_random(200, 80);
    setup_phase(16'd0, 16'd255, 16'd200, 16'd7);
    run_random(200, 80);
    calm = 1'b1;
    setup_phase(16'd50, 16'd0, 16'd0, 16'd1);
    run_random(280, 92);

    in_valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hlpf_pkg.sv
rtl/core/hlpf_div.sv
rtl/core/heartbeat_led_pulse_fader_core.sv
bench/hlpf_checker.sv
bench/testbench.sv
